// ===== design/radio_link_recovery_controller_macros.svh =====
// Assertion macros for the link recovery controller checker.
// They expect signals named clock and reset in the using scope.
`ifndef RADIO_LINK_RECOVERY_CONTROLLER_MACROS_SVH
`define RADIO_LINK_RECOVERY_CONTROLLER_MACROS_SVH

// same-cycle implication, off during reset
`define RLRC_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rlrc assertion failed");

// next-cycle implication, off during reset
`define RLRC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rlrc assertion failed");

// next-cycle implication, also checked while reset is high
`define RLRC_ASSERT_NEXT_ALWAYS(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("rlrc assertion failed");

`endif

// ===== design/rlrc_pkg.sv =====
package rlrc_pkg;

   localparam int RX_SLOTS_DEFAULT = 4;
   localparam int MAX_PACKET       = 255;

   localparam logic [31:0] WINDOW_MS_RESET = 32'd10000;
   localparam logic [7:0]  LIMIT_RESET     = 8'd3;

   typedef enum logic [0:0] {
      CSR_WINDOW_MS = 1'b0,
      CSR_LIMIT     = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      MODE_SEND         = 4'd0,
      MODE_RECV         = 4'd1,
      MODE_CLEAR        = 4'd2,
      MODE_BEGIN_RESET  = 4'd3,
      MODE_MARK_INIT    = 4'd4,
      MODE_BEGIN_TX     = 4'd5,
      MODE_TX_DONE      = 4'd6,
      MODE_TX_DEFER     = 4'd7,
      MODE_TX_TIMEOUT   = 4'd8,
      MODE_BUSY_TIMEOUT = 4'd9,
      MODE_IO_FAIL      = 4'd10,
      MODE_RECOVERY     = 4'd11,
      MODE_PUSH_RX      = 4'd12
   } mode_type;

   typedef enum logic [3:0] {
      ST_OK        = 4'd0,
      ST_NONE      = 4'd1,
      ST_INVALID   = 4'd2,
      ST_TOO_LARGE = 4'd3,
      ST_FAULT     = 4'd4,
      ST_BUSY      = 4'd5,
      ST_CAPACITY  = 4'd6,
      ST_TIMEOUT   = 4'd7,
      ST_IO        = 4'd8
   } status_type;

   typedef enum logic [2:0] {
      LS_OFF        = 3'd0,
      LS_STANDBY    = 3'd1,
      LS_RESETTING  = 3'd2,
      LS_RECOVERING = 3'd3,
      LS_RX         = 3'd4,
      LS_TX_PREPARE = 3'd5,
      LS_TX         = 3'd6,
      LS_FAULT      = 3'd7
   } link_state_type;

   // request beat, lowest bits first: now_ms, packet_length_in, buffer_capacity, recovery_ok
   typedef struct packed {
      logic [6:0]  pad;
      logic        recovery_ok;
      logic [7:0]  buffer_capacity;
      logic [7:0]  packet_length_in;
      logic [63:0] now_ms;
   } req_payload_type;

   // response beat, lowest bits first: status, link_state_now, packet_length_out,
   // slot_index, rx_waiting
   typedef struct packed {
      logic [3:0]     pad;
      logic [6:0]     rx_waiting;
      logic [5:0]     slot_index;
      logic [7:0]     packet_length_out;
      link_state_type link_state_now;
      status_type     status;
   } rsp_payload_type;

endpackage

// ===== design/radio_link_recovery_controller.sv =====
// Radio link recovery controller.
// One event per request beat: req_tuser carries the event code, req_tdata its
// time stamp, packet length, receive capacity and recovery result. Every event
// produces exactly one response beat with status, link state, delivered or
// started length, ring slot and the number of received packets held.
// csr_* writes the recovery window (index 0) and the attempt limit (index 1);
// csr_ready is always high; the user must only make writes while no event is in
// flight, as the block itself does not enforce it. An accepted beat is
// registered, evaluated against the link state, and its response registered.
// Throughput: one event per cycle unless the response stalls; the state update
// is a single pass of compare and select logic plus one 64-bit subtract and
// compare for the window. The receive ring is a RX_SLOTS deep memory read one
// entry ahead at the next head, so a recv sees the head length from a register.
// When rsp_tready is low the response holds; an empty input register still
// takes one more beat, then req_tready drops until the response is taken.
// Reset clears the link state, transmit pair, ring pointers and recovery
// window and restores the register defaults; ring contents are not cleared.
module radio_link_recovery_controller #(
   parameter int RX_SLOTS = rlrc_pkg::RX_SLOTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // now_ms[63:0], packet_length_in[71:64], buffer_capacity[79:72], recovery_ok[80]
   input  logic [87:0] req_tdata,
   // mode[3:0]
   input  logic [3:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status[3:0], link_state_now[6:4], packet_length_out[14:7], slot_index[20:15],
   // rx_waiting[27:21]
   output logic [31:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);
   import rlrc_pkg::*;

   localparam int IW = (RX_SLOTS > 1) ? $clog2(RX_SLOTS) : 1;
   localparam int FW = $clog2(RX_SLOTS + 1);
   localparam int SW = FW + 1;

   // input register
   logic            in_valid_ff;
   mode_type        in_mode_ff;
   req_payload_type in_data_ff;

   // response register
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   // configuration
   logic [31:0] window_ms_ff;
   logic [7:0]  limit_ff;

   // link state
   link_state_type link_ff, link_in;
   logic           tx_waiting_ff, tx_waiting_in;
   logic           tx_busy_ff, tx_busy_in;
   logic [7:0]     tx_bytes_ff, tx_bytes_in;
   logic [IW-1:0]  head_ff, head_in;
   logic [FW-1:0]  fill_ff, fill_in;
   logic           window_open_ff, window_open_in;
   logic [63:0]    window_start_ff, window_start_in;
   logic [7:0]     attempt_ff, attempt_in;

   // receive ring
   logic [7:0]    ring_mem [RX_SLOTS];
   logic [7:0]    head_len_ff;
   logic          ring_we;
   logic [IW-1:0] tail;
   logic [IW-1:0] head_next;
   logic [SW-1:0] tail_sum;

   logic advance;

   // recovery budget terms
   logic        running, expired, restart;
   logic [63:0] elapsed;
   logic [7:0]  att_base;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

   assign tail_sum  = SW'(head_ff) + SW'(fill_ff);
   assign tail      = (tail_sum >= SW'(RX_SLOTS)) ? IW'(tail_sum - SW'(RX_SLOTS))
                                                   : IW'(tail_sum);
   assign head_next = (head_ff == IW'(RX_SLOTS - 1)) ? '0 : head_ff + IW'(1);

   assign running = (link_ff == LS_RECOVERING) || (link_ff == LS_RESETTING);
   assign elapsed = in_data_ff.now_ms - window_start_ff;
   assign expired = window_open_ff && (in_data_ff.now_ms >= window_start_ff) &&
                    (elapsed >= {32'd0, window_ms_ff});
   assign restart  = !window_open_ff || (!running && expired);
   assign att_base = restart ? 8'd0 : attempt_ff;

   always_comb begin
      logic       recover;
      status_type err;

      recover         = 1'b0;
      err             = ST_IO;
      link_in         = link_ff;
      tx_waiting_in   = tx_waiting_ff;
      tx_busy_in      = tx_busy_ff;
      tx_bytes_in     = tx_bytes_ff;
      head_in         = head_ff;
      fill_in         = fill_ff;
      window_open_in  = window_open_ff;
      window_start_in = window_start_ff;
      attempt_in      = attempt_ff;
      ring_we         = 1'b0;
      rsp_data_in     = '0;
      rsp_data_in.status = ST_INVALID;

      case (in_mode_ff)
         MODE_SEND: begin
            if (in_data_ff.packet_length_in == 8'd0) begin
               rsp_data_in.status = ST_INVALID;
            end else if (32'(in_data_ff.packet_length_in) > MAX_PACKET) begin
               rsp_data_in.status = ST_TOO_LARGE;
            end else if (link_ff == LS_FAULT) begin
               rsp_data_in.status = ST_FAULT;
            end else if (link_ff != LS_RX && link_ff != LS_STANDBY) begin
               rsp_data_in.status = ST_BUSY;
            end else if (tx_waiting_ff || tx_busy_ff) begin
               rsp_data_in.status = ST_CAPACITY;
            end else begin
               tx_bytes_in        = in_data_ff.packet_length_in;
               tx_waiting_in      = 1'b1;
               rsp_data_in.status = ST_OK;
            end
         end
         MODE_RECV: begin
            if (fill_ff == '0) begin
               rsp_data_in.status = ST_NONE;
            end else if (head_len_ff > in_data_ff.buffer_capacity) begin
               rsp_data_in.status = ST_TOO_LARGE;
            end else begin
               rsp_data_in.packet_length_out = head_len_ff;
               rsp_data_in.slot_index        = 6'(head_ff);
               rsp_data_in.status            = ST_OK;
               head_in = head_next;
               fill_in = fill_ff - FW'(1);
            end
         end
         MODE_CLEAR: begin
            link_in            = LS_OFF;
            tx_waiting_in      = 1'b0;
            tx_busy_in         = 1'b0;
            tx_bytes_in        = 8'd0;
            head_in            = '0;
            fill_in            = '0;
            window_open_in     = 1'b0;
            window_start_in    = 64'd0;
            attempt_in         = 8'd0;
            rsp_data_in.status = ST_OK;
         end
         MODE_BEGIN_RESET: begin
            if (link_ff == LS_OFF || link_ff == LS_STANDBY || link_ff == LS_RECOVERING) begin
               if (link_ff == LS_OFF) begin
                  attempt_in     = 8'd0;
                  window_open_in = 1'b0;
               end
               link_in            = LS_RESETTING;
               rsp_data_in.status = ST_OK;
            end
         end
         MODE_MARK_INIT: begin
            if (link_ff == LS_RESETTING) begin
               link_in            = LS_RX;
               rsp_data_in.status = ST_OK;
            end
         end
         MODE_BEGIN_TX: begin
            if (tx_waiting_ff && link_ff == LS_RX) begin
               tx_waiting_in                 = 1'b0;
               tx_busy_in                    = 1'b1;
               link_in                       = LS_TX;
               rsp_data_in.packet_length_out = tx_bytes_ff;
               rsp_data_in.status            = ST_OK;
            end
         end
         MODE_TX_DONE, MODE_TX_DEFER: begin
            if (link_ff == LS_TX && tx_busy_ff) begin
               tx_busy_in = 1'b0;
               if (in_mode_ff == MODE_TX_DONE) begin
                  tx_bytes_in = 8'd0;
               end else begin
                  tx_waiting_in = 1'b1;
               end
               link_in            = LS_RX;
               rsp_data_in.status = ST_OK;
            end
         end
         MODE_TX_TIMEOUT: begin
            if (link_ff == LS_TX && tx_busy_ff) begin
               tx_busy_in    = 1'b0;
               tx_waiting_in = 1'b1;
               recover       = 1'b1;
               err           = ST_TIMEOUT;
            end
         end
         MODE_BUSY_TIMEOUT, MODE_IO_FAIL: begin
            // an in-flight packet goes back to waiting
            if (tx_busy_ff) begin
               tx_busy_in    = 1'b0;
               tx_waiting_in = 1'b1;
            end
            recover = 1'b1;
            err     = (in_mode_ff == MODE_IO_FAIL) ? ST_IO : ST_TIMEOUT;
         end
         MODE_RECOVERY: begin
            if (running) begin
               if (in_data_ff.recovery_ok) begin
                  link_in            = LS_RX;
                  rsp_data_in.status = ST_OK;
               end else begin
                  recover = 1'b1;
                  err     = ST_IO;
               end
            end
         end
         MODE_PUSH_RX: begin
            if (in_data_ff.packet_length_in == 8'd0) begin
               rsp_data_in.status = ST_INVALID;
            end else if (32'(in_data_ff.packet_length_in) > MAX_PACKET) begin
               rsp_data_in.status = ST_TOO_LARGE;
            end else if (link_ff != LS_RX) begin
               rsp_data_in.status = (link_ff == LS_FAULT) ? ST_FAULT : ST_BUSY;
            end else if (32'(fill_ff) >= RX_SLOTS) begin
               rsp_data_in.status = ST_CAPACITY;
            end else begin
               ring_we                = 1'b1;
               fill_in                = fill_ff + FW'(1);
               rsp_data_in.slot_index = 6'(tail);
               rsp_data_in.status     = ST_OK;
            end
         end
         default: begin
            rsp_data_in.status = ST_INVALID;
         end
      endcase

      if (recover) begin
         if (link_ff == LS_FAULT) begin
            rsp_data_in.status = ST_FAULT;
         end else begin
            if (restart) begin
               window_open_in  = 1'b1;
               window_start_in = in_data_ff.now_ms;
            end
            attempt_in = att_base;
            if (att_base >= limit_ff) begin
               link_in            = LS_FAULT;
               rsp_data_in.status = ST_FAULT;
            end else begin
               attempt_in         = att_base + 8'd1;
               link_in            = LS_RECOVERING;
               rsp_data_in.status = err;
            end
         end
      end

      rsp_data_in.link_state_now = link_in;
      rsp_data_in.rx_waiting     = 7'(fill_in);
   end

   always_comb begin
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         window_ms_ff    <= WINDOW_MS_RESET;
         limit_ff        <= LIMIT_RESET;
         link_ff         <= LS_OFF;
         tx_waiting_ff   <= 1'b0;
         tx_busy_ff      <= 1'b0;
         tx_bytes_ff     <= 8'd0;
         head_ff         <= '0;
         fill_ff         <= '0;
         window_open_ff  <= 1'b0;
         window_start_ff <= 64'd0;
         attempt_ff      <= 8'd0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_WINDOW_MS: window_ms_ff <= csr_data;
               CSR_LIMIT:     limit_ff     <= csr_data[7:0];
               default:       limit_ff     <= limit_ff;
            endcase
         end
         if (advance) begin
            link_ff         <= link_in;
            tx_waiting_ff   <= tx_waiting_in;
            tx_busy_ff      <= tx_busy_in;
            tx_bytes_ff     <= tx_bytes_in;
            head_ff         <= head_in;
            fill_ff         <= fill_in;
            window_open_ff  <= window_open_in;
            window_start_ff <= window_start_in;
            attempt_ff      <= attempt_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_mode_ff <= mode_type'(req_tuser);
         in_data_ff <= req_payload_type'(req_tdata);
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // ring memory: the head entry is read ahead into head_len_ff, with write forwarding
   always_ff @(posedge clock) begin
      if (advance && ring_we) begin
         ring_mem[tail] <= in_data_ff.packet_length_in;
      end
      if (advance && ring_we && tail == head_in) begin
         head_len_ff <= in_data_ff.packet_length_in;
      end else begin
         head_len_ff <= ring_mem[advance ? head_in : head_ff];
      end
   end

endmodule

// ===== design/rlrc_checker.sv =====
`include "radio_link_recovery_controller_macros.svh"

module rlrc_checker #(
   parameter int RX_SLOTS = rlrc_pkg::RX_SLOTS_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);
   import rlrc_pkg::*;

   rsp_payload_type rsp;

   assign rsp = rsp_payload_type'(rsp_tdata);

   `RLRC_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `RLRC_ASSERT_NEXT(a_rsp_stable, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))
   `RLRC_ASSERT_NEXT_ALWAYS(a_reset_clears, reset, !rsp_tvalid)
   // a nonzero length is only reported by a successful recv or begin_tx
   `RLRC_ASSERT_SAME(a_len_ok, rsp_tvalid && rsp.packet_length_out != 8'd0, rsp.status == ST_OK)
   `RLRC_ASSERT_SAME(a_fill_bound, rsp_tvalid, 32'(rsp.rx_waiting) <= RX_SLOTS)

endmodule

bind radio_link_recovery_controller rlrc_checker #(.RX_SLOTS(RX_SLOTS)) u_rlrc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== tb/tb_radio_link_recovery_controller.sv =====
`timescale 1ns / 1ps

module tb_radio_link_recovery_controller;
   import rlrc_pkg::*;

   localparam int SLOTS = RX_SLOTS_DEFAULT;
   localparam logic [3:0] MODE_UNUSED_FIRST = MODE_PUSH_RX + 4'd1;
   localparam logic [3:0] MODE_UNUSED_LAST  = 4'hF;
   localparam int ITEMS_PER_PHASE = 190;
   localparam int PHASES = 6;
   localparam int MAX_REPORTS = 100;

   // Shadow of the link controller: predicts one response per accepted event.
   class link_scoreboard;
      logic [31:0]     window_ms;
      logic [7:0]      limit;
      link_state_type  link;
      bit              tx_waiting;
      bit              tx_busy;
      logic [7:0]      tx_bytes;
      int unsigned     head;
      int unsigned     fill;
      logic [7:0]      ring [SLOTS];
      bit              win_open;
      logic [63:0]     win_start;
      logic [7:0]      attempts;
      rsp_payload_type pending_rsp [$];
      int unsigned     mismatches;
      int unsigned     checked;
      int unsigned     reports;
      int unsigned     faults;
      bit [15:0]       seen_status;
      bit [7:0]        seen_state;

      function new();
         window_ms = WINDOW_MS_RESET;
         limit = LIMIT_RESET;
         clear_link();
         mismatches = 0;
         checked = 0;
         reports = 0;
         faults = 0;
         seen_status = '0;
         seen_state = '0;
      endfunction

      function void clear_link();
         link = LS_OFF;
         tx_waiting = 1'b0;
         tx_busy = 1'b0;
         tx_bytes = '0;
         head = 0;
         fill = 0;
         foreach (ring[i]) ring[i] = '0;
         win_open = 1'b0;
         win_start = '0;
         attempts = '0;
      endfunction

      function void set_register(csr_index_type idx, logic [31:0] data);
         if (idx == CSR_WINDOW_MS) window_ms = data;
         else limit = data[7:0];
      endfunction

      // Budget check for a hardware failure; an expired window only restarts while
      // no recovery or reset is running.
      function status_type count_attempt(logic [63:0] now, status_type err);
         bit running;
         bit expired;
         if (link == LS_FAULT) return ST_FAULT;
         running = (link == LS_RECOVERING) || (link == LS_RESETTING);
         expired = win_open && (now >= win_start) &&
                   ((now - win_start) >= {32'd0, window_ms});
         if (!win_open || (!running && expired)) begin
            win_open = 1'b1;
            win_start = now;
            attempts = '0;
         end
         if (attempts >= limit) begin
            link = LS_FAULT;
            return ST_FAULT;
         end
         attempts = attempts + 8'd1;
         link = LS_RECOVERING;
         return err;
      endfunction

      function void requeue_in_flight();
         if (tx_busy) begin
            tx_busy = 1'b0;
            tx_waiting = 1'b1;
         end
      endfunction

      function void note_event(logic [3:0] mode, req_payload_type p);
         status_type      st;
         logic [7:0]      len_out;
         logic [5:0]      slot;
         link_state_type  prior;
         int unsigned     idx;
         rsp_payload_type r;
         st = ST_INVALID;
         len_out = '0;
         slot = '0;
         prior = link;
         case (mode)
            MODE_SEND: begin
               if (p.packet_length_in == 8'd0) st = ST_INVALID;
               else if (p.packet_length_in > MAX_PACKET) st = ST_TOO_LARGE;
               else if (link == LS_FAULT) st = ST_FAULT;
               else if (link != LS_RX && link != LS_STANDBY) st = ST_BUSY;
               else if (tx_waiting || tx_busy) st = ST_CAPACITY;
               else begin
                  tx_bytes = p.packet_length_in;
                  tx_waiting = 1'b1;
                  st = ST_OK;
               end
            end
            MODE_RECV: begin
               if (fill == 0) st = ST_NONE;
               else begin
                  idx = head % SLOTS;
                  if (ring[idx] > p.buffer_capacity) st = ST_TOO_LARGE;
                  else begin
                     len_out = ring[idx];
                     slot = idx[5:0];
                     head = (idx + 1) % SLOTS;
                     fill--;
                     st = ST_OK;
                  end
               end
            end
            MODE_CLEAR: begin
               clear_link();
               st = ST_OK;
            end
            MODE_BEGIN_RESET: begin
               if (link == LS_OFF || link == LS_STANDBY || link == LS_RECOVERING) begin
                  if (link == LS_OFF) begin
                     attempts = '0;
                     win_open = 1'b0;
                  end
                  link = LS_RESETTING;
                  st = ST_OK;
               end
            end
            MODE_MARK_INIT: begin
               if (link == LS_RESETTING) begin
                  link = LS_RX;
                  st = ST_OK;
               end
            end
            MODE_BEGIN_TX: begin
               if (tx_waiting && link == LS_RX) begin
                  tx_waiting = 1'b0;
                  tx_busy = 1'b1;
                  link = LS_TX;
                  len_out = tx_bytes;
                  st = ST_OK;
               end
            end
            MODE_TX_DONE, MODE_TX_DEFER: begin
               if (link == LS_TX && tx_busy) begin
                  tx_busy = 1'b0;
                  if (mode == MODE_TX_DONE) tx_bytes = '0;
                  else tx_waiting = 1'b1;
                  link = LS_RX;
                  st = ST_OK;
               end
            end
            MODE_TX_TIMEOUT: begin
               if (link == LS_TX && tx_busy) begin
                  tx_busy = 1'b0;
                  tx_waiting = 1'b1;
                  st = count_attempt(p.now_ms, ST_TIMEOUT);
               end
            end
            MODE_BUSY_TIMEOUT: begin
               requeue_in_flight();
               st = count_attempt(p.now_ms, ST_TIMEOUT);
            end
            MODE_IO_FAIL: begin
               requeue_in_flight();
               st = count_attempt(p.now_ms, ST_IO);
            end
            MODE_RECOVERY: begin
               if (link == LS_RECOVERING || link == LS_RESETTING) begin
                  if (p.recovery_ok) begin
                     link = LS_RX;
                     st = ST_OK;
                  end else st = count_attempt(p.now_ms, ST_IO);
               end
            end
            MODE_PUSH_RX: begin
               if (p.packet_length_in == 8'd0) st = ST_INVALID;
               else if (p.packet_length_in > MAX_PACKET) st = ST_TOO_LARGE;
               else if (link != LS_RX) st = (link == LS_FAULT) ? ST_FAULT : ST_BUSY;
               else if (fill >= SLOTS) st = ST_CAPACITY;
               else begin
                  idx = (head + fill) % SLOTS;
                  ring[idx] = p.packet_length_in;
                  fill++;
                  slot = idx[5:0];
                  st = ST_OK;
               end
            end
            default: st = ST_INVALID;
         endcase
         if (link == LS_FAULT && prior != LS_FAULT) faults++;
         seen_status[st] = 1'b1;
         seen_state[link] = 1'b1;
         r = '0;
         r.status = st;
         r.link_state_now = link;
         r.packet_length_out = len_out;
         r.slot_index = slot;
         r.rx_waiting = fill[6:0];
         pending_rsp.push_back(r);
      endfunction

      function void report(string what, logic [7:0] want_v, logic [7:0] got_v);
         if (want_v !== got_v) begin
            mismatches++;
            if (reports < MAX_REPORTS) begin
               reports++;
               $display("%0t mismatch on %s: expected %0d, got %0d", $time, what, want_v,
                        got_v);
            end
         end
      endfunction

      function void check_response(logic [31:0] raw);
         rsp_payload_type got;
         rsp_payload_type want;
         got = rsp_payload_type'(raw);
         checked++;
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (reports < MAX_REPORTS) begin
               reports++;
               $display("%0t mismatch: response %h with none expected, expected nothing",
                        $time, raw);
            end
            return;
         end
         want = pending_rsp.pop_front();
         report("status", want.status, got.status);
         report("link_state_now", want.link_state_now, got.link_state_now);
         report("packet_length_out", want.packet_length_out, got.packet_length_out);
         report("slot_index", want.slot_index, got.slot_index);
         report("rx_waiting", want.rx_waiting, got.rx_waiting);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [87:0] req_tdata = '0;   // now_ms, packet_length_in, buffer_capacity, recovery_ok
   logic [3:0]  req_tuser = '0;   // mode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // status, link_state_now, packet_length_out, slot, rx_waiting
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = 1'b0;
   logic [31:0] csr_data = '0;

   link_scoreboard sb;
   int          burst_left = 0;
   int unsigned events_sent = 0;
   int unsigned settings = 0;
   logic [63:0] ms_clock = '0;
   int          rcv_pattern = 0;
   int          rcv_left = 0;
   int unsigned rcv_cycle = 0;

   always #6 clock = ~clock;

   radio_link_recovery_controller #(.RX_SLOTS(SLOTS)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Response side: checks each beat, stalls on segments of varying duty.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
         if (rcv_left == 0) begin
            rcv_pattern = $urandom_range(3, 0);
            rcv_left = $urandom_range(200, 20);
         end else begin
            rcv_left--;
         end
         rcv_cycle++;
         case (rcv_pattern)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(9, 0) < 7);
            2: rsp_tready <= ($urandom_range(9, 0) < 3);
            default: rsp_tready <= (rcv_cycle[1:0] == 2'b11);
         endcase
      end
   end

   task automatic issue(input logic [3:0] mode, input req_payload_type p);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
         burst_left = ($urandom_range(9, 0) == 0) ? 150 : $urandom_range(16, 1);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= p;
      do @(posedge clock); while (!req_tready);
      sb.note_event(mode, p);
      events_sent++;
   endtask

   task automatic post_event(input logic [3:0] mode, input logic [63:0] now,
                             input logic [7:0] len, input logic [7:0] cap, input bit ok);
      req_payload_type p;
      p = '0;
      p.now_ms = now;
      p.packet_length_in = len;
      p.buffer_capacity = cap;
      p.recovery_ok = ok;
      issue(mode, p);
   endtask

   // Hold off the sender until every response is back, then let the block settle.
   task automatic wait_idle();
      int guard = 0;
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (sb.pending_rsp.size() != 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic program_link(input logic [31:0] window, input logic [7:0] lim);
      csr_valid <= 1'b1;
      csr_index <= CSR_WINDOW_MS;
      csr_data <= window;
      do @(posedge clock); while (!csr_ready);
      sb.set_register(CSR_WINDOW_MS, window);
      csr_index <= CSR_LIMIT;
      csr_data <= {24'd0, lim};
      do @(posedge clock); while (!csr_ready);
      sb.set_register(CSR_LIMIT, {24'd0, lim});
      csr_valid <= 1'b0;
      settings++;
   endtask

   // Mostly small steps, some landing exactly on the window edge, a few jumps
   // that may even go backwards.
   function automatic logic [63:0] next_time();
      int r;
      r = $urandom_range(99, 0);
      if (r < 60) ms_clock = ms_clock + 64'($urandom_range(20, 0));
      else if (r < 75) ms_clock = ms_clock + {32'd0, sb.window_ms};
      else if (r < 82) ms_clock = ms_clock + {32'd0, sb.window_ms} - 64'd1;
      else if (r < 92) ms_clock = ms_clock + {32'd0, $urandom};
      else ms_clock = {$urandom, $urandom};
      return ms_clock;
   endfunction

   function automatic logic [3:0] failure_mode();
      case ($urandom_range(2, 0))
         0: return MODE_BUSY_TIMEOUT;
         1: return MODE_IO_FAIL;
         default: return MODE_TX_TIMEOUT;
      endcase
   endfunction

   // Steers toward events that make progress from the predicted link state.
   task automatic pick_event(output logic [3:0] mode, output req_payload_type p);
      int r;
      int rl;
      r = $urandom_range(99, 0);
      mode = 4'($urandom_range(MODE_PUSH_RX, MODE_SEND));
      case (sb.link)
         LS_FAULT:
            if (r < 70) mode = MODE_CLEAR;
         LS_OFF:
            if (r < 75) mode = MODE_BEGIN_RESET;
         LS_RESETTING: begin
            if (r < 60) mode = MODE_MARK_INIT;
            else if (r < 75) mode = MODE_RECOVERY;
            else if (r < 85) mode = failure_mode();
         end
         LS_RECOVERING: begin
            if (r < 55) mode = MODE_RECOVERY;
            else if (r < 70) mode = MODE_BEGIN_RESET;
            else if (r < 80) mode = failure_mode();
         end
         LS_RX: begin
            if (r < 18) mode = MODE_SEND;
            else if (r < 38) mode = MODE_PUSH_RX;
            else if (r < 58) mode = MODE_RECV;
            else if (r < 73) mode = MODE_BEGIN_TX;
            else if (r < 77) mode = MODE_TX_DONE;
            else if (r < 89) mode = failure_mode();
            else if (r < 91) mode = MODE_CLEAR;
         end
         LS_TX: begin
            if (r < 25) mode = MODE_TX_DONE;
            else if (r < 40) mode = MODE_TX_DEFER;
            else if (r < 52) mode = MODE_TX_TIMEOUT;
            else if (r < 65) mode = MODE_RECV;
            else if (r < 75) mode = MODE_PUSH_RX;
            else if (r < 82) mode = MODE_SEND;
            else if (r < 88) mode = failure_mode();
         end
         default: ;
      endcase
      p = '0;
      p.now_ms = next_time();
      rl = $urandom_range(19, 0);
      if (rl == 0) p.packet_length_in = 8'd0;
      else if (rl == 1) p.packet_length_in = 8'd255;
      else p.packet_length_in = 8'($urandom_range(255, 1));
      rl = $urandom_range(9, 0);
      if (rl < 6) p.buffer_capacity = 8'd255;
      else if (rl == 6) p.buffer_capacity = 8'd0;
      else p.buffer_capacity = 8'($urandom_range(255, 0));
      p.recovery_ok = ($urandom_range(3, 0) != 0);
   endtask

   initial begin
      logic [3:0]      mode;
      req_payload_type p;
      int              made;
      int              directed;
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // directed part, register defaults
      post_event(MODE_RECV, 64'd0, 8'd0, 8'd255, 1'b0);
      post_event(MODE_UNUSED_FIRST, 64'd0, 8'd1, 8'd1, 1'b1);
      post_event(MODE_UNUSED_LAST, '1, 8'd255, 8'd255, 1'b1);
      post_event(MODE_SEND, 64'd5, 8'd5, 8'd0, 1'b0);
      post_event(MODE_SEND, 64'd5, 8'd0, 8'd0, 1'b0);
      post_event(MODE_PUSH_RX, 64'd5, 8'd7, 8'd0, 1'b0);
      post_event(MODE_BEGIN_RESET, 64'd6, 8'd0, 8'd0, 1'b0);
      post_event(MODE_MARK_INIT, 64'd6, 8'd0, 8'd0, 1'b0);
      post_event(MODE_PUSH_RX, 64'd7, 8'd0, 8'd0, 1'b0);
      post_event(MODE_PUSH_RX, 64'd7, 8'd255, 8'd0, 1'b0);
      post_event(MODE_PUSH_RX, 64'd7, 8'd1, 8'd0, 1'b0);
      post_event(MODE_PUSH_RX, 64'd7, 8'd128, 8'd0, 1'b0);
      post_event(MODE_PUSH_RX, 64'd7, 8'd64, 8'd0, 1'b0);
      post_event(MODE_PUSH_RX, 64'd7, 8'd9, 8'd0, 1'b0);      // ring full
      post_event(MODE_RECV, 64'd8, 8'd0, 8'd254, 1'b0);      // head too long
      post_event(MODE_RECV, 64'd8, 8'd0, 8'd255, 1'b0);
      post_event(MODE_SEND, 64'd8, 8'd255, 8'd0, 1'b0);
      post_event(MODE_SEND, 64'd8, 8'd3, 8'd0, 1'b0);        // transmit slot taken
      post_event(MODE_BEGIN_TX, 64'd9, 8'd0, 8'd0, 1'b0);
      post_event(MODE_TX_DEFER, 64'd9, 8'd0, 8'd0, 1'b0);
      post_event(MODE_BEGIN_TX, 64'd9, 8'd0, 8'd0, 1'b0);
      post_event(MODE_TX_TIMEOUT, '1, 8'd0, 8'd0, 1'b0);
      post_event(MODE_RECOVERY, 64'd0, 8'd0, 8'd0, 1'b0);
      post_event(MODE_RECOVERY, 64'd0, 8'd0, 8'd0, 1'b1);
      // time earlier than the window start: window still open
      post_event(MODE_IO_FAIL, 64'd0, 8'd0, 8'd0, 1'b0);
      post_event(MODE_BUSY_TIMEOUT, 64'd1, 8'd0, 8'd0, 1'b0); // budget used up
      post_event(MODE_PUSH_RX, 64'd1, 8'd4, 8'd0, 1'b0);
      post_event(MODE_CLEAR, 64'd1, 8'd0, 8'd0, 1'b0);
      directed = events_sent;

      for (int phase = 0; phase < PHASES; phase++) begin
         wait_idle();
         case (phase)
            0: program_link(32'd1, 8'd0);
            1: program_link(32'hFFFF_FFFF, 8'd255);
            2: program_link(WINDOW_MS_RESET, LIMIT_RESET);
            3: program_link($urandom_range(64, 1), 8'($urandom_range(4, 1)));
            4: program_link($urandom_range(32'hFFFF_FFFF, 1), 8'($urandom_range(255, 0)));
            default: program_link(32'd2, 8'd1);
         endcase
         made = 0;
         while (made < ITEMS_PER_PHASE) begin
            if ($urandom_range(99, 0) < 8) begin
               mode = 4'($urandom_range(MODE_UNUSED_LAST, MODE_SEND));
               p = '0;
               p.now_ms = {$urandom, $urandom};
               p.packet_length_in = 8'($urandom);
               p.buffer_capacity = 8'($urandom);
               p.recovery_ok = 1'($urandom);
            end else begin
               pick_event(mode, p);
               made++;
            end
            issue(mode, p);
            if ($urandom_range(299, 0) == 0) wait_idle();
         end
      end

      wait_idle();
      repeat (10) @(posedge clock);
      if (sb.pending_rsp.size() != 0) begin
         sb.mismatches++;
         $display("%0t mismatch: %0d responses expected, 0 arrived", $time,
                  sb.pending_rsp.size());
      end
      $display("Covered %0d events (%0d directed) over %0d register settings; %0d responses",
               events_sent, directed, settings, sb.checked);
      $display("checked, %0d of 9 status codes and %0d link states seen, %0d fault latches",
               $countones(sb.seen_status), $countones(sb.seen_state), sb.faults);
      if (sb.mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+design
design/rlrc_pkg.sv
design/radio_link_recovery_controller.sv
design/rlrc_checker.sv
tb/tb_radio_link_recovery_controller.sv
